@@ hdl/assert_macros.svh @@
// assertion helpers for the bcmm checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BCMM_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bcmm check failed");

// next-cycle implication
`define BCMM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bcmm check failed");

`endif

@@ hdl/bcmm_pkg.sv @@
package bcmm_pkg;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 3;
  localparam int VAL_W     = 16;
  localparam int SUM_W     = 40;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_OF_A   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_OF_B   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 2'd3;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

endpackage

@@ hdl/bcmm_in_if.sv @@
interface bcmm_in_if;
  logic                               valid;
  logic                               ready;
  logic        [bcmm_pkg::OP_W-1:0]   operation;
  logic        [bcmm_pkg::IDX_W-1:0]  index_row;
  logic        [bcmm_pkg::IDX_W-1:0]  index_col;
  logic        [bcmm_pkg::IDX_W-1:0]  index_slice;
  logic signed [bcmm_pkg::VAL_W-1:0]  value_re;
  logic signed [bcmm_pkg::VAL_W-1:0]  value_im;

  modport source (
    output valid, operation, index_row, index_col, index_slice, value_re, value_im,
    input  ready
  );
  modport sink (
    input  valid, operation, index_row, index_col, index_slice, value_re, value_im,
    output ready
  );
endinterface

@@ hdl/bcmm_out_if.sv @@
interface bcmm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bcmm_pkg::SUM_W-1:0]  sum_re;
  logic signed [bcmm_pkg::SUM_W-1:0]  sum_im;
  logic                               index_error;

  modport source (
    output valid, sum_re, sum_im, index_error,
    input  ready
  );
  modport sink (
    input  valid, sum_re, sum_im, index_error,
    output ready
  );
endinterface

@@ hdl/bcmm_ram.sv @@
module bcmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/batched_complex_matrix_multiply.sv @@
// batched complex matrix multiply
// in_bus carries load and query beats. a load (write A / write B) stores one
// complex element of a slice into the A or B memory in the cycle it is
// accepted and returns nothing; writes outside the store are dropped.
// a query names row, column and slice and returns one beat on out_bus: the
// exact 40-bit complex dot product of A's row with B's column over the
// configured inner size, or index_error with zero sums when an index lies
// outside the configured sizes.
// loads are accepted back to back while in_bus is ready. a query reads one
// A and one B element per cycle, nk of each, nk being inner_size capped at
// MAX_DIM; a read stage, a multiply stage, the accumulate and the output
// register follow. an index error or a zero inner size skips the reads.
// in_bus is not ready while a query runs, so a new query waits until the
// last reaches the output register. a finished result sits in the output
// register until taken; loads are still accepted then, a second query waits
// at its end for the register. cfg_we writes the size registers; the user
// must keep such writes between items, the block does not enforce it. reset
// (rst_n low, synchronous) sets all sizes to 8 and empties the pipeline;
// memory contents are undefined until written, no clearing pass.
module batched_complex_matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  bcmm_in_if.sink                             in_bus,
  bcmm_out_if.source                          out_bus,
  input  logic                                cfg_we,
  input  logic [bcmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcmm_pkg::CFG_W-1:0]          cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = bcmm_pkg::SUM_W;
  localparam int CW    = bcmm_pkg::CFG_W;
  localparam int VW    = bcmm_pkg::VAL_W;
  localparam int EW    = 2 * VW;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_t;

  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] s, logic [CW-1:0] r,
                                            logic [CW-1:0] c);
    return (AW'(s) * AW'(MAX_DIM) + AW'(r)) * AW'(MAX_DIM) + AW'(c);
  endfunction

  function automatic logic [CW-1:0] limit_dim(logic [CW-1:0] v);
    return (int'(v) > MAX_DIM) ? CW'(MAX_DIM) : v;
  endfunction

  state_t               state_r;
  logic [CW-1:0]        rows_r, inner_r, cols_r, slices_r;
  logic [CW-1:0]        q_row_r, q_col_r, q_slice_r, k_r, nk_r;
  logic                 rd_vld_r, prod_vld_r;
  logic signed [EW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [SW-1:0] acc_re_r, acc_im_r;
  logic                 err_r;
  logic                 out_valid_r;
  logic signed [SW-1:0] out_re_r, out_im_r;
  logic                 out_err_r;

  logic                 in_fire, in_range, q_err, out_load;
  logic [CW-1:0]        in_row, in_col, in_slice, nk_in;
  logic [AW-1:0]        waddr, a_raddr, b_raddr;
  logic [EW-1:0]        wdata, a_rdata, b_rdata;
  logic                 we_a, we_b;

  assign in_bus.ready = (state_r != S_RUN) && (state_r != S_DRAIN) && (state_r != S_DONE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  assign in_row   = CW'(in_bus.index_row);
  assign in_col   = CW'(in_bus.index_col);
  assign in_slice = CW'(in_bus.index_slice);
  assign nk_in    = limit_dim(inner_r);

  assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM)
                 && (int'(in_slice) < MAX_DIM);
  assign q_err    = (in_row >= limit_dim(rows_r)) || (in_col >= limit_dim(cols_r))
                 || (in_slice >= limit_dim(slices_r));

  assign waddr = addr_of(in_slice, in_row, in_col);
  assign wdata = {in_bus.value_re, in_bus.value_im};
  assign we_a  = in_fire && in_range && (in_bus.operation == bcmm_pkg::OP_WRITE_A);
  assign we_b  = in_fire && in_range && (in_bus.operation == bcmm_pkg::OP_WRITE_B);

  assign a_raddr = addr_of(q_slice_r, q_row_r, k_r);
  assign b_raddr = addr_of(q_slice_r, k_r, q_col_r);

  bcmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  bcmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // multiply stage
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      p_rr_r <= $signed(a_rdata[EW-1:VW]) * $signed(b_rdata[EW-1:VW]);
      p_ii_r <= $signed(a_rdata[VW-1:0])  * $signed(b_rdata[VW-1:0]);
      p_ri_r <= $signed(a_rdata[EW-1:VW]) * $signed(b_rdata[VW-1:0]);
      p_ir_r <= $signed(a_rdata[VW-1:0])  * $signed(b_rdata[EW-1:VW]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rows_r      <= bcmm_pkg::CFG_RESET;
      inner_r     <= bcmm_pkg::CFG_RESET;
      cols_r      <= bcmm_pkg::CFG_RESET;
      slices_r    <= bcmm_pkg::CFG_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bcmm_pkg::CFG_ROWS_OF_A:   rows_r   <= cfg_data;
          bcmm_pkg::CFG_INNER_SIZE:  inner_r  <= cfg_data;
          bcmm_pkg::CFG_COLS_OF_B:   cols_r   <= cfg_data;
          bcmm_pkg::CFG_SLICE_COUNT: slices_r <= cfg_data;
          default: ;
        endcase
      end

      rd_vld_r   <= (state_r == S_RUN);
      prod_vld_r <= rd_vld_r;

      if (prod_vld_r) begin
        acc_re_r <= acc_re_r + SW'(p_rr_r) - SW'(p_ii_r);
        acc_im_r <= acc_im_r + SW'(p_ri_r) + SW'(p_ir_r);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire && (in_bus.operation == bcmm_pkg::OP_QUERY)) begin
            q_row_r   <= in_row;
            q_col_r   <= in_col;
            q_slice_r <= in_slice;
            k_r       <= '0;
            nk_r      <= nk_in;
            acc_re_r  <= '0;
            acc_im_r  <= '0;
            err_r     <= q_err;
            if (q_err || (nk_in == '0)) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          k_r <= k_r + CW'(1);
          if (k_r == nk_r - CW'(1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld_r && !prod_vld_r) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_re_r    <= acc_re_r;
            out_im_r    <= acc_im_r;
            out_err_r   <= err_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.sum_re      = out_re_r;
  assign out_bus.sum_im      = out_im_r;
  assign out_bus.index_error = out_err_r;

endmodule

@@ hdl/bcmm_checker.sv @@
`include "assert_macros.svh"

module bcmm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [bcmm_pkg::OP_W-1:0]         in_operation,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bcmm_pkg::SUM_W-1:0] out_sum_re,
  input logic signed [bcmm_pkg::SUM_W-1:0] out_sum_im,
  input logic                              out_index_error
);

  // result beat holds until taken
  `BCMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // index error comes with zero sums
  `BCMM_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_index_error,
                   (out_sum_re == '0) && (out_sum_im == '0))

  // an accepted query blocks the input for at least the next cycle
  `BCMM_ASSERT_NEXT(a_query_busy, clk, rst_n,
                    in_valid && in_ready && (in_operation == bcmm_pkg::OP_QUERY), !in_ready)

  // a new result only appears at the end of a query
  `BCMM_ASSERT_NOW(a_out_after_query, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind batched_complex_matrix_multiply bcmm_checker u_bcmm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .in_operation    (in_bus.operation),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_sum_re      (out_bus.sum_re),
  .out_sum_im      (out_bus.sum_im),
  .out_index_error (out_bus.index_error)
);

@@ verif/batched_complex_matrix_multiply_test.sv @@
module batched_complex_matrix_multiply_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bcmm_pkg::*;

  localparam int DIM = 8;
  localparam int ITEMS = 1600;
  localparam int PHASES = 10;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic [IDX_W-1:0]        slice;
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
  } beat_t;

  typedef struct {
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
    logic                    err;
  } entry_t;

  typedef struct {
    bit                   setup;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    beat_t                b;
    bit                   typed;
    entry_t               want;
  } step_t;

  localparam entry_t NO_ENTRY = '{default: 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bcmm_in_if in_bus ();
  bcmm_out_if out_bus ();

  batched_complex_matrix_multiply dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10ns clk = ~clk;

  // mirror of the block
  logic [2*VAL_W-1:0] a_mem [DIM*DIM*DIM];
  logic [2*VAL_W-1:0] b_mem [DIM*DIM*DIM];
  bit a_set [DIM*DIM*DIM];
  bit b_set [DIM*DIM*DIM];
  logic [CFG_W-1:0] rows_reg = CFG_RESET;
  logic [CFG_W-1:0] inner_reg = CFG_RESET;
  logic [CFG_W-1:0] cols_reg = CFG_RESET;
  logic [CFG_W-1:0] slices_reg = CFG_RESET;

  entry_t awaited_entries [$];
  bit calm = 1'b0;
  int mismatches = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int errors_seen = 0;
  int items_counted = 0;
  int size_settings = 0;
  int unsigned cycles = 0;

  function automatic int size_of(logic [CFG_W-1:0] v);
    return (v > DIM) ? DIM : int'(v);
  endfunction

  function automatic int slot(int s, int r, int c);
    return (s * DIM + r) * DIM + c;
  endfunction

  function automatic bit misses_range(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                      logic [IDX_W-1:0] s);
    return r >= size_of(rows_reg) || c >= size_of(cols_reg) || s >= size_of(slices_reg);
  endfunction

  function automatic entry_t product_entry(beat_t b);
    entry_t e;
    longint acc_re;
    longint acc_im;
    longint ar, ai, br, bi;
    logic [2*VAL_W-1:0] wa, wb;
    e = NO_ENTRY;
    acc_re = 0;
    acc_im = 0;
    if (misses_range(b.row, b.col, b.slice)) begin
      e.err = 1'b1;
      return e;
    end
    for (int k = 0; k < size_of(inner_reg); k++) begin
      wa = a_mem[slot(b.slice, b.row, k)];
      wb = b_mem[slot(b.slice, k, b.col)];
      ar = $signed(wa[2*VAL_W-1:VAL_W]);
      ai = $signed(wa[VAL_W-1:0]);
      br = $signed(wb[2*VAL_W-1:VAL_W]);
      bi = $signed(wb[VAL_W-1:0]);
      acc_re += ar * br - ai * bi;
      acc_im += ar * bi + ai * br;
    end
    e.re = acc_re[SUM_W-1:0];
    e.im = acc_im[SUM_W-1:0];
    return e;
  endfunction

  function automatic void absorb(beat_t b);
    if (b.op == OP_WRITE_A) begin
      a_mem[slot(b.slice, b.row, b.col)] = {b.re, b.im};
      a_set[slot(b.slice, b.row, b.col)] = 1'b1;
    end else if (b.op == OP_WRITE_B) begin
      b_mem[slot(b.slice, b.row, b.col)] = {b.re, b.im};
      b_set[slot(b.slice, b.row, b.col)] = 1'b1;
    end
  endfunction

  function automatic beat_t beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                                 logic [IDX_W-1:0] c, logic [IDX_W-1:0] s,
                                 logic signed [VAL_W-1:0] re,
                                 logic signed [VAL_W-1:0] im);
    beat_t b;
    b.op = op;
    b.row = r;
    b.col = c;
    b.slice = s;
    b.re = re;
    b.im = im;
    return b;
  endfunction

  function automatic step_t ld(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                               logic [IDX_W-1:0] c, logic [IDX_W-1:0] s,
                               logic signed [VAL_W-1:0] re,
                               logic signed [VAL_W-1:0] im);
    step_t t;
    t.setup = 1'b0;
    t.reg_idx = '0;
    t.reg_val = '0;
    t.b = beat(op, r, c, s, re, im);
    t.typed = 1'b0;
    t.want = NO_ENTRY;
    return t;
  endfunction

  function automatic step_t qr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                               logic [IDX_W-1:0] s);
    return ld(OP_QUERY, r, c, s, '0, '0);
  endfunction

  function automatic step_t qk(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                               logic [IDX_W-1:0] s, logic signed [SUM_W-1:0] wre,
                               logic signed [SUM_W-1:0] wim, logic werr);
    step_t t;
    t = qr(r, c, s);
    t.typed = 1'b1;
    t.want.re = wre;
    t.want.im = wim;
    t.want.err = werr;
    return t;
  endfunction

  function automatic step_t sz(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    step_t t;
    t = ld(OP_UNUSED, '0, '0, '0, '0, '0);
    t.setup = 1'b1;
    t.reg_idx = idx;
    t.reg_val = val;
    return t;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r == 2) return '0;
    return VAL_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] pick_size(int p);
    int r;
    if (p == 0) return CFG_RESET;
    if (p == 1) return 4'd1;
    if (p == 2) return 4'd15;
    r = $urandom_range(0, 9);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'd15;
    return CFG_W'($urandom_range(1, DIM));
  endfunction

  function automatic logic [IDX_W-1:0] in_range(logic [CFG_W-1:0] v);
    int n;
    n = size_of(v);
    return IDX_W'((n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, DIM - 1));
  endfunction

  function automatic bit sender_idles();
    return !calm && $urandom_range(0, 99) < 21;
  endfunction

  task automatic drive_beat(beat_t b, bit typed, entry_t want);
    while (sender_idles()) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.operation <= b.op;
    in_bus.index_row <= b.row;
    in_bus.index_col <= b.col;
    in_bus.index_slice <= b.slice;
    in_bus.value_re <= b.re;
    in_bus.value_im <= b.im;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (b.op == OP_QUERY) begin
      awaited_entries.push_back(typed ? want : product_entry(b));
      queries_sent++;
    end else if (b.op != OP_UNUSED) begin
      loads_sent++;
    end
    if (b.op != OP_UNUSED) items_counted++;
    absorb(b);
  endtask

  // loads every operand the query would read that is still unknown,
  // and refreshes some of the rest, then sends the query
  task automatic ask_entry(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c, logic [IDX_W-1:0] s);
    if (!misses_range(r, c, s)) begin
      for (int k = 0; k < size_of(inner_reg); k++) begin
        if (!a_set[slot(s, r, k)] || $urandom_range(0, 3) == 0)
          drive_beat(beat(OP_WRITE_A, r, IDX_W'(k), s, pick_value(), pick_value()), 1'b0,
                     NO_ENTRY);
        if (!b_set[slot(s, k, c)] || $urandom_range(0, 3) == 0)
          drive_beat(beat(OP_WRITE_B, IDX_W'(k), c, s, pick_value(), pick_value()), 1'b0,
                     NO_ENTRY);
      end
    end
    drive_beat(beat(OP_QUERY, r, c, s, pick_value(), pick_value()), 1'b0, NO_ENTRY);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (awaited_entries.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_ROWS_OF_A:   rows_reg = val;
      CFG_INNER_SIZE:  inner_reg = val;
      CFG_COLS_OF_B:   cols_reg = val;
      CFG_SLICE_COUNT: slices_reg = val;
      default: ;
    endcase
  endtask

  task automatic program_sizes(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k,
                               logic [CFG_W-1:0] c, logic [CFG_W-1:0] s);
    set_reg(CFG_ROWS_OF_A, r);
    set_reg(CFG_INNER_SIZE, k);
    set_reg(CFG_COLS_OF_B, c);
    set_reg(CFG_SLICE_COUNT, s);
    cfg_we <= 1'b0;
    size_settings++;
  endtask

  task automatic report(string why, entry_t want, entry_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected re=%0d im=%0d err=%0b, got re=%0d im=%0d err=%0b", why,
               want.re, want.im, want.err, got.re, got.im, got.err);
  endtask

  // result side: random back-pressure and checking
  always @(posedge clk) begin : result_side
    entry_t got;
    entry_t want;
    out_bus.ready <= calm || $urandom_range(0, 99) >= 21;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.re = out_bus.sum_re;
      got.im = out_bus.sum_im;
      got.err = out_bus.index_error;
      if (got.err === 1'b1) errors_seen++;
      if (awaited_entries.size() == 0) begin
        report("result beat with none awaited", NO_ENTRY, got);
      end else begin
        want = awaited_entries.pop_front();
        if (got.re !== want.re || got.im !== want.im || got.err !== want.err)
          report("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("batched_complex_matrix_multiply regression: fail");
      $finish;
    end
  end

  initial begin
    step_t plan [$];
    int roll;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_WRITE_A;
    in_bus.index_row = '0;
    in_bus.index_col = '0;
    in_bus.index_slice = '0;
    in_bus.value_re = '0;
    in_bus.value_im = '0;
    out_bus.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROWS_OF_A;
    cfg_data = '0;

    plan = '{
      sz(CFG_INNER_SIZE, 4'd1),
      ld(OP_WRITE_A, 0, 0, 0, 16'sh7fff, 16'sh7fff),
      ld(OP_WRITE_B, 0, 0, 0, 16'sh7fff, 16'sh8000),
      qk(0, 0, 0, 40'sd2147385345, -40'sd32767, 1'b0),
      ld(OP_WRITE_A, 0, 0, 0, 16'sh8000, 16'sh8000),
      ld(OP_WRITE_B, 0, 0, 0, 16'sh8000, 16'sh8000),
      qk(0, 0, 0, 40'sd0, 40'sd2147483648, 1'b0),
      ld(OP_WRITE_A, 7, 0, 7, 16'sh7fff, 16'sh8000),
      ld(OP_WRITE_B, 0, 7, 7, 16'sh8000, 16'sh7fff),
      qr(7, 7, 7),
      ld(OP_UNUSED, 5, 5, 5, 16'shffff, 16'shffff),
      sz(CFG_ROWS_OF_A, 4'd1),
      qk(1, 0, 0, 40'sd0, 40'sd0, 1'b1),
      qk(7, 7, 7, 40'sd0, 40'sd0, 1'b1),
      sz(CFG_COLS_OF_B, 4'd1),
      qk(0, 1, 0, 40'sd0, 40'sd0, 1'b1),
      sz(CFG_SLICE_COUNT, 4'd1),
      qk(0, 0, 1, 40'sd0, 40'sd0, 1'b1),
      qk(0, 0, 0, 40'sd0, 40'sd2147483648, 1'b0),
      sz(CFG_INNER_SIZE, 4'd0),
      qk(0, 0, 0, 40'sd0, 40'sd0, 1'b0),
      sz(CFG_ROWS_OF_A, 4'd0),
      qk(0, 0, 0, 40'sd0, 40'sd0, 1'b1),
      sz(CFG_ROWS_OF_A, 4'd15),
      sz(CFG_COLS_OF_B, 4'd0),
      qk(0, 0, 0, 40'sd0, 40'sd0, 1'b1),
      sz(CFG_COLS_OF_B, 4'd15),
      sz(CFG_SLICE_COUNT, 4'd0),
      qk(0, 0, 0, 40'sd0, 40'sd0, 1'b1),
      sz(CFG_SLICE_COUNT, 4'd15),
      qk(7, 7, 7, 40'sd0, 40'sd0, 1'b0)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[n]) begin
      if (plan[n].setup) begin
        settle();
        set_reg(plan[n].reg_idx, plan[n].reg_val);
        cfg_we <= 1'b0;
      end else begin
        drive_beat(plan[n].b, plan[n].typed, plan[n].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      calm <= (p == 5);
      program_sizes(pick_size(p), pick_size(p), pick_size(p), pick_size(p));
      while (items_counted < (p + 1) * ITEMS / PHASES) begin
        roll = $urandom_range(0, 99);
        if (roll < 65)
          ask_entry(in_range(rows_reg), in_range(cols_reg), in_range(slices_reg));
        else if (roll < 80)
          ask_entry(IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
        else if (roll < 95)
          drive_beat(beat($urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A, IDX_W'($urandom),
                          IDX_W'($urandom), IDX_W'($urandom), pick_value(), pick_value()),
                     1'b0, NO_ENTRY);
        else
          drive_beat(beat(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                          pick_value(), pick_value()), 1'b0, NO_ENTRY);
      end
    end

    in_bus.valid <= 1'b0;
    while (awaited_entries.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("ran %0d loads and %0d queries, %0d of them index errors, over %0d size settings",
             loads_sent, queries_sent, errors_seen, size_settings + 1);
    $display("%0d result beats disagreed with the predicted entries", mismatches);
    if (mismatches == 0 && awaited_entries.size() == 0) begin
      $display("batched_complex_matrix_multiply regression: pass");
    end else begin
      $display("batched_complex_matrix_multiply regression: fail");
    end
    $finish;
  end

endmodule
